@@ hdl/cda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_pkg: shared types, constants and calendar helpers
// Item and queue entry types, sequencer states, field limits and the
// month length and date check functions used by the front and back parts.
// ----------------------------------------------------------------------------
package cda_pkg;

	// field limits
	localparam int SEC_MAX   = 59;
	localparam int SEC_WRAP  = 60;
	localparam int MIN_MAX   = 59;
	localparam int MIN_WRAP  = 60;
	localparam int HOUR_MAX  = 23;
	localparam int HOUR_WRAP = 24;
	localparam int MON_MAX   = 12;
	localparam int MON_WRAP  = 12;

	// calendar after reset: year 10, january 1, midnight
	localparam logic [7:0] RST_SEC  = 8'd0;
	localparam logic [7:0] RST_MIN  = 8'd0;
	localparam logic [7:0] RST_HOUR = 8'd0;
	localparam logic [7:0] RST_DAY  = 8'd1;
	localparam logic [7:0] RST_MON  = 8'd1;
	localparam logic [7:0] RST_YEAR = 8'd10;

	// stream widths
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 40;
	localparam int M_USER_W = 2;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// what the back part does with a queued word
	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_LOAD   = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	// classified word passed from front to back
	typedef struct packed {
		kind_t      kind;
		logic [6:0] sec;
		logic [6:0] min;
		logic [6:0] hour;
		logic [6:0] day;
		logic [6:0] mon;
		logic [7:0] year;
	} item_t;

	// back sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_SEC  = 3'd1,
		ST_MIN  = 3'd2,
		ST_HOUR = 3'd3,
		ST_DAY  = 3'd4,
		ST_MON  = 3'd5,
		ST_DONE = 3'd6
	} seq_state_t;

	// days in a month, zero for a month code outside january..december
	function automatic logic [4:0] month_len(input logic [7:0] month, input logic leap);
		logic [4:0] len;
		len = 5'd0;
		unique case (month) inside
			8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: len = 5'd31;
			8'd4, 8'd6, 8'd9, 8'd11:                    len = 5'd30;
			8'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	// range and month length check of a full date-time
	function automatic logic date_ok(
		input logic [7:0] s,
		input logic [7:0] mi,
		input logic [7:0] h,
		input logic [7:0] d,
		input logic [7:0] mo,
		input logic       leap
	);
		logic ok;
		ok = (s <= 8'(SEC_MAX)) && (mi <= 8'(MIN_MAX)) && (h <= 8'(HOUR_MAX)) &&
		     (d != 8'd0) && (mo != 8'd0) && (mo <= 8'(MON_MAX)) &&
		     (d <= {3'b000, month_len(mo, leap)});
		return ok;
	endfunction

endpackage

@@ hdl/cda_leap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_leap: gregorian leap year test on a year offset
// The base year is fixed at elaboration, so the century years that fall in
// the 256 year window are found up front and only small compares remain.
// ----------------------------------------------------------------------------
module cda_leap #(
	parameter int BASE_YEAR = 2000
) (
	input  logic [7:0] year,
	output logic       leap
);

	// base year split into what the leap rule needs
	localparam int BASE_MOD4 = BASE_YEAR % 4;
	localparam int CEN_OFF0  = (100 - (BASE_YEAR % 100)) % 100;
	localparam int CEN_OFF1  = CEN_OFF0 + 100;
	localparam int CEN_OFF2  = CEN_OFF0 + 200;
	localparam bit CEN_LEAP0 = ((BASE_YEAR + CEN_OFF0) % 400) == 0;
	localparam bit CEN_LEAP1 = ((BASE_YEAR + CEN_OFF1) % 400) == 0;
	localparam bit CEN_LEAP2 = ((BASE_YEAR + CEN_OFF2) % 400) == 0;

	logic [1:0] mod4;
	logic       skip_cen;

	// divisible by four
	assign mod4 = year[1:0] + 2'(BASE_MOD4);

	// century years that are not divisible by four hundred
	assign skip_cen = ((32'(year) == CEN_OFF0) && !CEN_LEAP0) ||
	                  ((32'(year) == CEN_OFF1) && !CEN_LEAP1) ||
	                  ((32'(year) == CEN_OFF2) && !CEN_LEAP2);

	assign leap = (mod4 == 2'd0) && !skip_cen;

endmodule

@@ hdl/cda_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_fifo: short word queue between front and back
// Flop based first-in first-out queue of classified words, read from the head.
// ----------------------------------------------------------------------------
module cda_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cda_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output cda_pkg::item_t head_item
);

	localparam int PTR_W = $clog2(cda_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(cda_pkg::QUEUE_DEPTH + 1);

	cda_pkg::item_t   entry_q [cda_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(cda_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(cda_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(cda_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ hdl/cda_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_front: input side, takes words and classifies them
// Unpacks the input word, checks a load against the calendar rules and
// marks it as add, load or rejected load before it enters the queue.
// ----------------------------------------------------------------------------
module cda_front #(
	parameter int BASE_YEAR = 2000
) (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cda_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          s_tuser,
	input  logic                          queue_full,
	output logic                          push,
	output cda_pkg::item_t                push_item
);

	logic in_leap;
	logic load_ok;

	cda_leap #(
		.BASE_YEAR (BASE_YEAR)
	) u_leap (
		.year (s_tdata[42:35]),
		.leap (in_leap)
	);

	// take a word whenever the queue has room
	assign s_tready = !queue_full;
	assign push     = s_tvalid && !queue_full;

	// validity of a load
	assign load_ok = cda_pkg::date_ok(8'(s_tdata[6:0]), 8'(s_tdata[13:7]), 8'(s_tdata[20:14]),
	                                  8'(s_tdata[27:21]), 8'(s_tdata[34:28]), in_leap);

	// classify and unpack
	always_comb begin
		push_item.sec  = s_tdata[6:0];
		push_item.min  = s_tdata[13:7];
		push_item.hour = s_tdata[20:14];
		push_item.day  = s_tdata[27:21];
		push_item.mon  = s_tdata[34:28];
		push_item.year = s_tdata[42:35];
		if (!s_tuser) begin
			push_item.kind = cda_pkg::KIND_ADD;
		end else if (load_ok) begin
			push_item.kind = cda_pkg::KIND_LOAD;
		end else begin
			push_item.kind = cda_pkg::KIND_REJECT;
		end
	end

endmodule

@@ hdl/cda_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_back: calendar register and carry sequencer
// Holds the date-time, ripples carries one step a cycle from seconds up to
// months, and presents each result in an output register.
// ----------------------------------------------------------------------------
module cda_back #(
	parameter int BASE_YEAR = 2000
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  cda_pkg::item_t                head_item,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cda_pkg::M_DATA_W-1:0]  m_tdata,
	output logic [cda_pkg::M_USER_W-1:0]  m_tuser
);

	cda_pkg::seq_state_t state_q;
	cda_pkg::seq_state_t state_nxt;

	// calendar, wide enough to hold a sum before its carries are taken out
	logic [7:0] sec_q;
	logic [7:0] min_q;
	logic [7:0] hour_q;
	logic [7:0] day_q;
	logic [7:0] mon_q;
	logic [7:0] year_q;

	// addends applied after the day carry
	logic [6:0] mon_add_q;
	logic [7:0] year_add_q;
	logic       rejected_q;

	logic                         m_tvalid_q;
	logic [cda_pkg::M_DATA_W-1:0] m_tdata_q;
	logic [cda_pkg::M_USER_W-1:0] m_tuser_q;

	logic       leap;
	logic [4:0] cur_len;
	logic       out_free;
	logic       out_load;

	cda_leap #(
		.BASE_YEAR (BASE_YEAR)
	) u_leap (
		.year (year_q),
		.leap (leap)
	);

	assign cur_len  = cda_pkg::month_len(mon_q, leap);
	assign out_free = !m_tvalid_q || m_tready;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cda_pkg::ST_IDLE: begin
				if (head_valid) begin
					state_nxt = (head_item.kind == cda_pkg::KIND_ADD) ?
					            cda_pkg::ST_SEC : cda_pkg::ST_DONE;
				end
			end
			cda_pkg::ST_SEC: begin
				if (sec_q <= 8'(cda_pkg::SEC_MAX)) begin
					state_nxt = cda_pkg::ST_MIN;
				end
			end
			cda_pkg::ST_MIN: begin
				if (min_q <= 8'(cda_pkg::MIN_MAX)) begin
					state_nxt = cda_pkg::ST_HOUR;
				end
			end
			cda_pkg::ST_HOUR: begin
				if (hour_q <= 8'(cda_pkg::HOUR_MAX)) begin
					state_nxt = cda_pkg::ST_DAY;
				end
			end
			cda_pkg::ST_DAY: begin
				if (cur_len == 5'd0 || day_q <= {3'b000, cur_len}) begin
					state_nxt = cda_pkg::ST_MON;
				end
			end
			cda_pkg::ST_MON: begin
				if (mon_q <= 8'(cda_pkg::MON_MAX)) begin
					state_nxt = cda_pkg::ST_DONE;
				end
			end
			cda_pkg::ST_DONE: begin
				if (out_free) begin
					state_nxt = cda_pkg::ST_IDLE;
				end
			end
			default: state_nxt = cda_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop      = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			cda_pkg::ST_IDLE: pop      = head_valid;
			cda_pkg::ST_DONE: out_load = out_free;
			default: begin
				pop      = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cda_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// calendar update, one carry step a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q      <= cda_pkg::RST_SEC;
			min_q      <= cda_pkg::RST_MIN;
			hour_q     <= cda_pkg::RST_HOUR;
			day_q      <= cda_pkg::RST_DAY;
			mon_q      <= cda_pkg::RST_MON;
			year_q     <= cda_pkg::RST_YEAR;
			rejected_q <= 1'b0;
		end else begin
			unique case (state_q)
				cda_pkg::ST_IDLE: begin
					if (head_valid) begin
						rejected_q <= (head_item.kind == cda_pkg::KIND_REJECT);
						if (head_item.kind == cda_pkg::KIND_ADD) begin
							sec_q  <= sec_q + 8'(head_item.sec);
							min_q  <= min_q + 8'(head_item.min);
							hour_q <= hour_q + 8'(head_item.hour);
							day_q  <= day_q + 8'(head_item.day);
						end else if (head_item.kind == cda_pkg::KIND_LOAD) begin
							sec_q  <= 8'(head_item.sec);
							min_q  <= 8'(head_item.min);
							hour_q <= 8'(head_item.hour);
							day_q  <= 8'(head_item.day);
							mon_q  <= 8'(head_item.mon);
							year_q <= head_item.year;
						end
					end
				end
				cda_pkg::ST_SEC: begin
					if (sec_q > 8'(cda_pkg::SEC_MAX)) begin
						sec_q <= sec_q - 8'(cda_pkg::SEC_WRAP);
						min_q <= min_q + 8'd1;
					end
				end
				cda_pkg::ST_MIN: begin
					if (min_q > 8'(cda_pkg::MIN_MAX)) begin
						min_q  <= min_q - 8'(cda_pkg::MIN_WRAP);
						hour_q <= hour_q + 8'd1;
					end
				end
				cda_pkg::ST_HOUR: begin
					if (hour_q > 8'(cda_pkg::HOUR_MAX)) begin
						hour_q <= hour_q - 8'(cda_pkg::HOUR_WRAP);
						day_q  <= day_q + 8'd1;
					end
				end
				cda_pkg::ST_DAY: begin
					if (cur_len != 5'd0 && day_q > {3'b000, cur_len}) begin
						day_q <= day_q - {3'b000, cur_len};
						if (mon_q >= 8'(cda_pkg::MON_MAX)) begin
							mon_q  <= 8'd1;
							year_q <= year_q + 8'd1;
						end else begin
							mon_q <= mon_q + 8'd1;
						end
					end else begin
						// day settled, bring in the month addend
						mon_q <= mon_q + 8'(mon_add_q);
					end
				end
				cda_pkg::ST_MON: begin
					if (mon_q > 8'(cda_pkg::MON_MAX)) begin
						mon_q  <= mon_q - 8'(cda_pkg::MON_WRAP);
						year_q <= year_q + 8'd1;
					end else begin
						year_q <= year_q + year_add_q;
					end
				end
				cda_pkg::ST_DONE: begin
					rejected_q <= rejected_q;
				end
				default: begin
					rejected_q <= rejected_q;
				end
			endcase
		end
	end

	// month and year addends held through the carry steps
	always_ff @(posedge clk) begin
		if (pop) begin
			mon_add_q  <= head_item.mon;
			year_add_q <= head_item.year;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {6'd0, year_q, mon_q[3:0], day_q[4:0], hour_q[4:0],
			              min_q[5:0], sec_q[5:0]};
			m_tuser_q <= {rejected_q,
			              cda_pkg::date_ok(sec_q, min_q, hour_q, day_q, mon_q, leap)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ hdl/calendar_duration_adder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_duration_adder: calendar date-time with duration add and load
// Keeps year, month, day, hour, minute and second; adds durations with
// rippled carries and gregorian month lengths, or loads a checked date-time.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser op, tdata duration or date-time
//  m_      | out | m_tvalid/m_tready  | tuser flags, tdata current date-time
//
//  one result word for each input word, in order
//  an add steps through idle, seconds, minutes, hours, day, month and done:
//  each of seconds, minutes, hours, day and month carries loops on its own
//  field one subtract a cycle; a load or rejected load goes from idle to done
//  a two word queue lets the input keep taking words while a sum is carried,
//  and the output register holds a stalled result while the next one runs
//  reset gives year 10, january 1, 00:00:00 and empties queue and output
//
module calendar_duration_adder #(
	parameter int BASE_YEAR = 2000
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// sec[6:0] min[13:7] hour[20:14] day[27:21] month[34:28] year[42:35] zero[47:43]
	input  logic [cda_pkg::S_DATA_W-1:0]  s_tdata,
	// op: 0 add, 1 load
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// second[5:0] minute[11:6] hour[16:12] day[21:17] month[25:22] year[33:26] zero[39:34]
	output logic [cda_pkg::M_DATA_W-1:0]  m_tdata,
	// time_valid[0] load_rejected[1]
	output logic [cda_pkg::M_USER_W-1:0]  m_tuser
);

	logic           queue_full;
	logic           push;
	cda_pkg::item_t push_item;
	logic           pop;
	logic           head_valid;
	cda_pkg::item_t head_item;

	// accept and classify
	cda_front #(
		.BASE_YEAR (BASE_YEAR)
	) u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	// queue between the two sides
	cda_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// calendar and carries
	cda_back #(
		.BASE_YEAR (BASE_YEAR)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

@@ hdl/cda_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_checker: port level checks of the calendar adder
// Watches the output stream for held words and for date-time ranges.
// ----------------------------------------------------------------------------
module cda_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [cda_pkg::M_DATA_W-1:0]  m_tdata,
	input logic [cda_pkg::M_USER_W-1:0]  m_tuser
);

	// a stalled output word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	else $error("output word changed while stalled");

	// carries leave every field in range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:0] <= 6'd59) && (m_tdata[11:6] <= 6'd59) &&
		             (m_tdata[16:12] <= 5'd23) && (m_tdata[21:17] != 5'd0) &&
		             (m_tdata[25:22] != 4'd0) && (m_tdata[25:22] <= 4'd12))
	else $error("date-time field out of range");

	// a word flagged valid has no day past its month's length in a leap year
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			!((m_tdata[25:22] == 4'd2) && (m_tdata[21:17] > 5'd29)) &&
			!((m_tdata[21:17] == 5'd31) &&
			  ((m_tdata[25:22] == 4'd4) || (m_tdata[25:22] == 4'd6) ||
			   (m_tdata[25:22] == 4'd9) || (m_tdata[25:22] == 4'd11))))
	else $error("valid flag on a day past month end");

	// no result may come out of an idle block right after reset
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_tvalid)
	else $error("output word right after reset");

endmodule

bind calendar_duration_adder cda_checker u_cda_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for calendar_duration_adder
// Streams add and load words through the block with bursty input and a
// stalling output, predicts each current date-time from its own calendar
// copy and compares every result word field by field in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int BASE_YEAR    = 2000;
	localparam bit OP_ADD       = 1'b0;
	localparam bit OP_LOAD      = 1'b1;
	localparam int RANDOM_WORDS = 1050;
	localparam int SETTLE_WAIT  = 40;
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 500000;

	// one input word: op plus six duration or date-time fields
	typedef struct {
		bit       op;
		bit [6:0] secs;
		bit [6:0] mins;
		bit [6:0] hours;
		bit [6:0] days;
		bit [6:0] months;
		bit [7:0] years;
	} duration_word_t;

	// one result word
	typedef struct {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] day;
		logic [3:0] month;
		logic [7:0] year;
		logic       valid;
		logic       rejected;
	} date_time_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [cda_pkg::S_DATA_W-1:0]   s_tdata;
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [cda_pkg::M_DATA_W-1:0]   m_tdata;
	logic [cda_pkg::M_USER_W-1:0]   m_tuser;

	duration_word_t pending_words[$];
	date_time_t     expected_times[$];

	// calendar copy kept by the predictor
	int cal_sec, cal_min, cal_hour, cal_day, cal_mon, cal_year;

	int err_count;
	int cycle_count;
	int results_seen;
	bit s_accepted;
	int burst_left;
	int gap_left;
	int hold_left;
	int holds_done;
	int hold_at;
	int rx_cycle;

	calendar_duration_adder #(
		.BASE_YEAR(BASE_YEAR)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// gregorian leap rule on the full year
	function automatic bit leap_year(int year_off);
		int y;
		y = BASE_YEAR + year_off;
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int days_in_month(int month, int year_off);
		case (month)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(year_off) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	function automatic bit date_valid(int s, int mi, int h, int d, int mo, int y);
		if (s > 59 || mi > 59 || h > 23)
			return 1'b0;
		if (d == 0 || mo == 0 || mo > 12)
			return 1'b0;
		return d <= days_in_month(mo, y);
	endfunction

	function automatic duration_word_t make_word(bit op, int s, int mi, int h, int d,
		int mo, int y);
		duration_word_t w;
		w.op     = op;
		w.secs   = s[6:0];
		w.mins   = mi[6:0];
		w.hours  = h[6:0];
		w.days   = d[6:0];
		w.months = mo[6:0];
		w.years  = y[7:0];
		return w;
	endfunction

	// apply one word to the calendar copy and return the current date-time
	function automatic date_time_t advance_calendar(duration_word_t w);
		date_time_t r;
		int len;
		r.rejected = 1'b0;
		if (w.op == OP_LOAD) begin
			if (date_valid(w.secs, w.mins, w.hours, w.days, w.months, w.years)) begin
				cal_sec  = w.secs;
				cal_min  = w.mins;
				cal_hour = w.hours;
				cal_day  = w.days;
				cal_mon  = w.months;
				cal_year = w.years;
			end else begin
				r.rejected = 1'b1;
			end
		end else begin
			// carries ripple upward one field at a time
			cal_sec += w.secs;
			while (cal_sec > 59) begin
				cal_sec -= 60;
				cal_min++;
			end
			cal_min += w.mins;
			while (cal_min > 59) begin
				cal_min -= 60;
				cal_hour++;
			end
			cal_hour += w.hours;
			while (cal_hour > 23) begin
				cal_hour -= 24;
				cal_day++;
			end
			// day carry, december rolls into january of the next year
			cal_day += w.days;
			forever begin
				len = days_in_month(cal_mon, cal_year);
				if (len == 0 || cal_day <= len)
					break;
				cal_day -= len;
				cal_mon++;
				if (cal_mon > 12) begin
					cal_mon  = 1;
					cal_year = (cal_year + 1) % 256;
				end
			end
			// month add leaves the day unclamped
			cal_mon += w.months;
			while (cal_mon > 12) begin
				cal_mon -= 12;
				cal_year = (cal_year + 1) % 256;
			end
			cal_year = (cal_year + w.years) % 256;
		end
		r.second = cal_sec[5:0];
		r.minute = cal_min[5:0];
		r.hour   = cal_hour[4:0];
		r.day    = cal_day[4:0];
		r.month  = cal_mon[3:0];
		r.year   = cal_year[7:0];
		r.valid  = date_valid(cal_sec, cal_min, cal_hour, cal_day, cal_mon, cal_year);
		return r;
	endfunction

	// random word: mostly adds and valid loads, some broken and raw loads
	function automatic duration_word_t random_word();
		int pick, s, mi, h, d, mo, y, len;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			// small add, each field sometimes full range
			s  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
			mi = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
			h  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 3);
			d  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 3);
			mo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 1);
			y  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : 0;
			return make_word(OP_ADD, s, mi, h, d, mo, y);
		end
		if (pick < 55)
			return make_word(OP_ADD, $urandom_range(0, 127), $urandom_range(0, 127),
				$urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
				$urandom_range(0, 255));
		if (pick >= 90)
			return make_word(OP_LOAD, $urandom_range(0, 127), $urandom_range(0, 127),
				$urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
				$urandom_range(0, 255));
		// valid date-time, often near the end of a day or month
		mo  = $urandom_range(1, 12);
		y   = $urandom_range(0, 255);
		len = days_in_month(mo, y);
		d   = ($urandom_range(0, 1) == 0) ? len - $urandom_range(0, 1) : $urandom_range(1, len);
		h   = ($urandom_range(0, 1) == 0) ? 23 : $urandom_range(0, 23);
		mi  = ($urandom_range(0, 1) == 0) ? 59 : $urandom_range(0, 59);
		s   = ($urandom_range(0, 1) == 0) ? 59 - $urandom_range(0, 2) : $urandom_range(0, 59);
		if (pick >= 80) begin
			// break exactly one field
			case ($urandom_range(0, 5))
				0: s  = $urandom_range(60, 127);
				1: mi = $urandom_range(60, 127);
				2: h  = $urandom_range(24, 127);
				3: d  = $urandom_range(len + 1, 127);
				4: d  = 0;
				default: mo = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 127);
			endcase
		end
		return make_word(OP_LOAD, s, mi, h, d, mo, y);
	endfunction

	function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
				got_v);
			err_count++;
		end
	endfunction

	// stimulus list, reset and end of run
	initial begin
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		m_tready   = 1'b0;
		arst_n     = 1'b0;
		err_count  = 0;
		cal_sec    = 0;
		cal_min    = 0;
		cal_hour   = 0;
		cal_day    = 1;
		cal_mon    = 1;
		cal_year   = 10;

		// directed words
		pending_words.push_back(make_word(OP_ADD, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(OP_ADD, 127, 127, 127, 127, 127, 255));
		pending_words.push_back(make_word(OP_LOAD, 59, 59, 23, 31, 12, 255));
		pending_words.push_back(make_word(OP_ADD, 1, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(OP_LOAD, 0, 0, 12, 31, 1, 23));
		pending_words.push_back(make_word(OP_ADD, 0, 0, 0, 0, 1, 0));
		pending_words.push_back(make_word(OP_ADD, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(OP_LOAD, 30, 30, 6, 29, 2, 0));
		pending_words.push_back(make_word(OP_LOAD, 0, 0, 0, 29, 2, 100));
		pending_words.push_back(make_word(OP_LOAD, 0, 0, 0, 29, 2, 96));
		pending_words.push_back(make_word(OP_ADD, 0, 0, 0, 0, 0, 1));
		pending_words.push_back(make_word(OP_LOAD, 60, 0, 0, 1, 1, 0));
		pending_words.push_back(make_word(OP_LOAD, 0, 60, 0, 1, 1, 0));
		pending_words.push_back(make_word(OP_LOAD, 0, 0, 24, 1, 1, 0));
		pending_words.push_back(make_word(OP_LOAD, 0, 0, 0, 0, 1, 0));
		pending_words.push_back(make_word(OP_LOAD, 0, 0, 0, 1, 0, 0));
		pending_words.push_back(make_word(OP_LOAD, 0, 0, 0, 1, 13, 0));
		pending_words.push_back(make_word(OP_LOAD, 0, 0, 0, 31, 4, 0));
		pending_words.push_back(make_word(OP_LOAD, 127, 127, 127, 127, 127, 255));
		pending_words.push_back(make_word(OP_LOAD, 0, 0, 0, 1, 1, 0));
		pending_words.push_back(make_word(OP_ADD, 0, 0, 0, 127, 0, 0));
		pending_words.push_back(make_word(OP_LOAD, 59, 59, 23, 31, 12, 200));
		pending_words.push_back(make_word(OP_ADD, 0, 0, 0, 0, 127, 0));
		pending_words.push_back(make_word(OP_ADD, 127, 0, 0, 0, 0, 0));
		for (int i = 0; i < RANDOM_WORDS; i++)
			pending_words.push_back(random_word());

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain, then let the block settle
		while (pending_words.size() != 0 || expected_times.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
		if (err_count == 0 && expected_times.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// input driver: bursts of words with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			burst_left <= $urandom_range(1, 16);
			gap_left   <= 0;
		end else if (s_tvalid && !s_accepted) begin
			// word still offered, hold it
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			s_tvalid <= 1'b0;
		end else if (pending_words.size() != 0) begin
			s_tvalid <= 1'b1;
			s_tuser  <= pending_words[0].op;
			s_tdata  <= {5'b0, pending_words[0].years, pending_words[0].months,
				pending_words[0].days, pending_words[0].hours, pending_words[0].mins,
				pending_words[0].secs};
			if (burst_left <= 1) begin
				burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
					$urandom_range(1, 12);
				gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// output stall pattern, with two long hold-offs to fill the block
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			hold_left  <= 0;
			holds_done <= 0;
			hold_at    <= 150;
			rx_cycle   = 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (holds_done < 2 && results_seen >= hold_at) begin
			hold_left  <= LONG_HOLD;
			holds_done <= holds_done + 1;
			hold_at    <= 700;
			m_tready   <= 1'b0;
		end else begin
			rx_cycle++;
			case ((rx_cycle / 48) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				2: m_tready <= (rx_cycle % 4 == 0);
				default: m_tready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// predict on each accepted input word, check each accepted result word
	always @(posedge clk or negedge arst_n) begin
		duration_word_t w;
		date_time_t     exp_t;
		if (!arst_n) begin
			s_accepted   <= 1'b0;
			results_seen <= 0;
		end else begin
			s_accepted <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				w = make_word(s_tuser, s_tdata[6:0], s_tdata[13:7], s_tdata[20:14],
					s_tdata[27:21], s_tdata[34:28], s_tdata[42:35]);
				void'(pending_words.pop_front());
				expected_times.push_back(advance_calendar(w));
			end
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_times.size() == 0) begin
					$display("%0t ns: unexpected result word, expected none, actual %h/%b",
						$time, m_tdata, m_tuser);
					err_count++;
				end else begin
					exp_t = expected_times.pop_front();
					check_field("second", exp_t.second, m_tdata[5:0]);
					check_field("minute", exp_t.minute, m_tdata[11:6]);
					check_field("hour", exp_t.hour, m_tdata[16:12]);
					check_field("day", exp_t.day, m_tdata[21:17]);
					check_field("month", exp_t.month, m_tdata[25:22]);
					check_field("year", exp_t.year, m_tdata[33:26]);
					check_field("time_valid", exp_t.valid, m_tuser[0]);
					check_field("load_rejected", exp_t.rejected, m_tuser[1]);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d words pending and %0d results expected",
				$time, pending_words.size(), expected_times.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial cycle_count = 0;

endmodule

@@ calendar_duration_adder.f @@
hdl/cda_pkg.sv
hdl/cda_leap.sv
hdl/cda_fifo.sv
hdl/cda_front.sv
hdl/cda_back.sv
hdl/calendar_duration_adder.sv
hdl/cda_checker.sv
sim/testbench.sv
